/* src/tksd_pkg.sv */
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types and constants of the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

   localparam int LINE_CAPACITY = 32;
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int CMD_W = 4;
   localparam int INDEX_W = 5;
   localparam int TYPED_LEN_W = 6;

   localparam logic [CHAR_W-1:0] BYTE_BS = 8'd8;
   localparam logic [CHAR_W-1:0] BYTE_LF = 8'd10;
   localparam logic [CHAR_W-1:0] BYTE_CR = 8'd13;
   localparam logic [CHAR_W-1:0] BYTE_ESC = 8'd27;
   localparam logic [CHAR_W-1:0] BYTE_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] BYTE_BRACKET = 8'd91;
   localparam logic [CHAR_W-1:0] BYTE_BACKQUOTE = 8'd96;
   localparam logic [CHAR_W-1:0] BYTE_TILDE = 8'd126;
   localparam logic [CHAR_W-1:0] BYTE_DEL = 8'd127;
   localparam logic [CHAR_W-1:0] BYTE_UP = 8'd65;
   localparam logic [CHAR_W-1:0] BYTE_DOWN = 8'd66;
   localparam logic [CHAR_W-1:0] BYTE_RIGHT = 8'd67;
   localparam logic [CHAR_W-1:0] BYTE_LEFT = 8'd68;
   localparam logic [CHAR_W-1:0] BYTE_ONE = 8'd49;
   localparam logic [CHAR_W-1:0] BYTE_TWO = 8'd50;
   localparam logic [CHAR_W-1:0] BYTE_FIVE = 8'd53;

   typedef enum logic [CMD_W-1:0] {
      ACT_NONE        = 4'd0,
      ACT_RIGHT       = 4'd1,
      ACT_LEFT        = 4'd2,
      ACT_UP          = 4'd3,
      ACT_DOWN        = 4'd4,
      ACT_SHIFT_LEFT  = 4'd5,
      ACT_ENTER       = 4'd6,
      ACT_SHIFT_RIGHT = 4'd7,
      ACT_LINE        = 4'd8,
      ACT_QUIT        = 4'd9
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } line_access_type;

   typedef struct packed {
      cmd_type          command;
      logic [LEN_W-1:0] length;
      logic             read_hit;
   } step_result_type;

endpackage

/* src/tksd_line_ram.sv */
// ----------------------------------------------------------------------------
// tksd_line_ram
// Line buffer storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tksd_line_ram (
   input  logic                         clock,
   input  tksd_pkg::line_access_type    access,
   output logic [tksd_pkg::CHAR_W-1:0]  rd_data
);
   import tksd_pkg::*;

   logic [CHAR_W-1:0] line_mem [LINE_CAPACITY];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         line_mem[access.wr_addr] <= access.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (access.rd_en) begin
         rd_data_ff <= line_mem[access.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tksd_parser.sv */
// ----------------------------------------------------------------------------
// tksd_parser
// Escape sequence state machine and line length; issues line buffer accesses.
// ----------------------------------------------------------------------------
module tksd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [tksd_pkg::KIND_W-1:0]   kind,
   input  logic [tksd_pkg::CHAR_W-1:0]   data_byte,
   input  logic [tksd_pkg::INDEX_W-1:0]  read_index,
   output tksd_pkg::line_access_type     access,
   output tksd_pkg::step_result_type     result
);
   import tksd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ESC   = 2'd1,
      ST_CSI   = 2'd2,
      ST_TILDE = 2'd3
   } parse_state_type;

   parse_state_type  state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;
   cmd_type          command;
   logic             plain;
   logic             read_hit;

   function automatic logic kept_char(input logic [CHAR_W-1:0] b);
      kept_char = (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122) ||
                  (b >= 8'd48 && b <= 8'd57) || (b == BYTE_SPACE);
   endfunction

   always_comb begin
      state_in = state_ff;
      length_in = length_ff;
      command = ACT_NONE;
      plain = 1'b0;
      read_hit = 1'b0;
      access = '0;
      access.wr_addr = length_ff[ADDR_W-1:0];
      access.wr_data = data_byte;
      access.rd_addr = ADDR_W'(read_index);

      unique case (kind)
         KIND_BYTE: begin
            if (data_byte == BYTE_BACKQUOTE) begin
               command = ACT_QUIT;
            end else begin
               unique case (state_ff)
                  ST_IDLE: begin
                     if (data_byte == BYTE_ESC) begin
                        state_in = ST_ESC;
                     end else begin
                        plain = 1'b1;
                     end
                  end
                  ST_ESC: begin
                     if (data_byte == BYTE_BRACKET) begin
                        state_in = ST_CSI;
                     end else begin
                        state_in = ST_IDLE;
                        plain = 1'b1;
                     end
                  end
                  ST_CSI: begin
                     state_in = ST_IDLE;
                     case (data_byte)
                        BYTE_UP:    command = ACT_UP;
                        BYTE_DOWN:  command = ACT_DOWN;
                        BYTE_RIGHT: command = ACT_RIGHT;
                        BYTE_LEFT:  command = ACT_LEFT;
                        BYTE_TWO: begin
                           command = ACT_SHIFT_LEFT;
                           state_in = ST_TILDE;
                        end
                        BYTE_ONE: begin
                           command = ACT_ENTER;
                           state_in = ST_TILDE;
                        end
                        BYTE_FIVE: begin
                           command = ACT_SHIFT_RIGHT;
                           state_in = ST_TILDE;
                        end
                        default: plain = 1'b1;
                     endcase
                  end
                  ST_TILDE: begin
                     state_in = ST_IDLE;
                     plain = (data_byte != BYTE_TILDE);
                  end
                  default: state_in = ST_IDLE;
               endcase
            end

            if (plain) begin
               if (data_byte == BYTE_BS || data_byte == BYTE_DEL) begin
                  if (length_ff != '0) begin
                     length_in = length_ff - LEN_W'(1);
                  end
               end else if (kept_char(data_byte)) begin
                  if (length_ff < LEN_W'(LINE_CAPACITY)) begin
                     access.wr_en = 1'b1;
                     length_in = length_ff + LEN_W'(1);
                  end
               end else if (data_byte == BYTE_LF || data_byte == BYTE_CR) begin
                  command = ACT_LINE;
               end
            end
         end
         KIND_CLEAR: begin
            length_in = '0;
         end
         KIND_READ: begin
            access.rd_en = 1'b1;
            read_hit = (32'(read_index) < 32'(length_ff)) &&
                       (32'(read_index) < 32'(LINE_CAPACITY));
         end
         default: begin
         end
      endcase

      access.wr_en = access.wr_en & accept;
      access.rd_en = access.rd_en & accept;
      result.command = command;
      result.length = length_in;
      result.read_hit = read_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         length_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         length_ff <= length_in;
      end
   end

endmodule

/* src/terminal_key_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Turns terminal bytes into game commands and keeps a typed line buffer.
// ----------------------------------------------------------------------------
// Use:
//   Input words arrive on req_*: req_tuser carries the item kind (byte,
//   clear buffer, read buffer character), req_tdata the byte and the read
//   index. Every accepted word gives exactly one response word on rsp_*
//   with the command, the line length after the word and the read character.
// Throughput and pipeline:
//   One word per cycle while the response is not stalled. The accepting
//   edge starts the line buffer read and loads the middle register; the
//   output register loads from the middle register as it advances.
//   Parser state and line length update at the accepting edge, so the next
//   word sees them with no interlock; a read in a later word than a write
//   to the same entry gets the new character from the memory.
// Reset:
//   Parser goes idle and the line length goes to zero. Buffer contents are
//   not cleared; only entries below the length are ever returned.
// Stall:
//   When rsp_tready is low, the response holds and the middle stage fills;
//   req_tready then drops until the output register drains.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], read_index[12:8], zero pad
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // command[3:0], typed_length[9:4],
                                   // read_char[17:10], zero pad
);
   import tksd_pkg::*;

   logic                  accept;
   line_access_type       access;
   step_result_type       result;
   logic [CHAR_W-1:0]     rd_data;

   logic                  mid_valid_ff;
   step_result_type       mid_result_ff;
   logic                  mid_advance;

   logic                  out_valid_ff;
   logic [CMD_W-1:0]      out_command_ff;
   logic [TYPED_LEN_W-1:0] out_length_ff;
   logic [CHAR_W-1:0]     out_char_ff;

   assign mid_advance = mid_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !mid_valid_ff || mid_advance;
   assign accept = req_tvalid && req_tready;

   tksd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_tuser),
      .data_byte  (req_tdata[7:0]),
      .read_index (req_tdata[12:8]),
      .access     (access),
      .result     (result)
   );

   tksd_line_ram u_line_ram (
      .clock   (clock),
      .access  (access),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (accept) begin
         mid_valid_ff <= 1'b1;
      end else if (mid_advance) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_result_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (mid_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_advance) begin
         out_command_ff <= mid_result_ff.command;
         out_length_ff <= TYPED_LEN_W'(mid_result_ff.length);
         out_char_ff <= mid_result_ff.read_hit ? rd_data : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_char_ff, out_length_ff, out_command_ff};

endmodule

/* src/tksd_checker.sv */
// ----------------------------------------------------------------------------
// tksd_checker
// Port-level checks of the terminal key sequence decoder.
// ----------------------------------------------------------------------------
module tksd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import tksd_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[9:4]) <= LINE_CAPACITY)
      else $error("line length beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:0] != ACT_NONE) |-> rsp_tdata[17:10] == 8'd0)
      else $error("read character on a command response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the output empty");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
